[sv/jfd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and axis arithmetic for the joystick frame decoder.
package jfd_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CHECKSUM = 2'd1,
    STATUS_TYPE     = 2'd2
  } status_t;

  localparam logic [1:0] REG_ADC_OFFSET = 2'd0;
  localparam logic [1:0] REG_INNER_ZONE = 2'd1;
  localparam logic [1:0] REG_OUTER_ZONE = 2'd2;

  localparam logic [9:0] ADC_OFFSET_RESET = 10'd9;
  localparam logic [6:0] INNER_ZONE_RESET = 7'd20;
  localparam logic [6:0] OUTER_ZONE_RESET = 7'd60;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] TYPE_BYTE  = 8'h83;

  localparam logic [4:0] POS_HUNT    = 5'd0;
  localparam logic [4:0] POS_TYPE    = 5'd3;
  localparam logic [4:0] POS_DIGITAL = 5'd12;
  localparam logic [4:0] POS_ANALOG  = 5'd13;
  localparam logic [4:0] POS_CHECK   = 5'd17;

  localparam logic [9:0]  AXIS_MAX   = 10'd1023;
  localparam logic [17:0] AXIS_SCALE = 18'd200;
  localparam logic [10:0] DIV_RANGE  = 11'd1023;
  localparam logic [7:0]  MAP_CENTER = 8'd100;

  localparam int BTN_ONE_BIT   = 5;
  localparam int BTN_TWO_BIT   = 3;
  localparam int BTN_THREE_BIT = 4;
  localparam int BTN_FOUR_BIT  = 2;

  localparam logic signed [2:0] ZONE_MID     = 3'sd0;
  localparam logic signed [2:0] ZONE_NEG_FAR = -3'sd2;
  localparam logic signed [2:0] ZONE_POS_FAR = 3'sd2;

  localparam logic [7:0] CMD_X_MID  = 8'h01;
  localparam logic [7:0] CMD_X_NEG  = 8'h02;
  localparam logic [7:0] CMD_Y_MID  = 8'h04;
  localparam logic [7:0] CMD_Y_NEG  = 8'h08;
  localparam logic [7:0] CMD_BUTTON = 8'h80;

  typedef struct packed {
    status_t     status;
    logic [3:0]  buttons;
    logic [17:0] prod_y;
    logic [17:0] prod_x;
  } stage_t;

  function automatic logic [17:0] axis_product(input logic [7:0] hi, input logic [7:0] lo,
                                               input logic [9:0] offset);
    logic [16:0] diff;
    logic [9:0]  clamped;
    diff = {1'b0, hi, lo} - {7'b0, offset};
    if (diff[16]) begin
      clamped = 10'd0;
    end else if (diff[15:10] != 6'd0) begin
      clamped = AXIS_MAX;
    end else begin
      clamped = diff[9:0];
    end
    return {8'b0, clamped} * AXIS_SCALE;
  endfunction

  function automatic logic signed [2:0] axis_zone(input logic [17:0] prod,
                                                  input logic [6:0] inner,
                                                  input logic [6:0] outer);
    logic [7:0]  q0;
    logic [10:0] rem;
    logic [7:0]  q;
    logic [7:0]  mag;
    logic        neg;
    logic [2:0]  z;
    q0  = prod[17:10];
    rem = {1'b0, prod[9:0]} + {3'b0, q0};
    q   = q0 + {7'b0, (rem >= DIV_RANGE)};
    neg = (q < MAP_CENTER);
    mag = neg ? (MAP_CENTER - q) : (q - MAP_CENTER);
    if (mag <= {1'b0, inner}) begin
      z = 3'd0;
    end else if (mag <= {1'b0, outer}) begin
      z = 3'd1;
    end else begin
      z = 3'd2;
    end
    if (neg) begin
      z = ~z + 3'd1;
    end
    return $signed(z);
  endfunction

endpackage

[sv/joystick_frame_decoder.sv]
`timescale 1ns / 1ps
// Top level of the joystick frame decoder: frame parser, axis math and command update.
// A result leaves stage one on the checksum or type byte and passes stage two to the outputs.
// Throughput: one byte per cycle unless out_ready stalls the three one-transaction stages.
// Stage one parses and scales the axes, stage two divides, zones and updates the command byte.
// Reset clears the parser to hunting, the command byte to zero and the registers to defaults.
// Stored digital and analog bytes are not reset; each frame writes them before use.
module joystick_frame_decoder
  import jfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [9:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [7:0]        command_bits,
  output logic              button_one,
  output logic              button_two,
  output logic              button_three,
  output logic              button_four,
  output logic signed [2:0] x_zone,
  output logic signed [2:0] y_zone
);

  logic [9:0] adc_offset;
  logic [6:0] inner_zone_limit;
  logic [6:0] outer_zone_limit;

  logic       s1_valid;
  logic [7:0] s1_byte;

  logic [4:0] frame_position;
  logic [4:0] frame_position_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [7:0] digital_byte;
  logic [7:0] analog_bytes [4];
  logic [4:0] analog_offset;
  logic [1:0] analog_index;

  logic       s1_has_result;
  stage_t     s1_result;
  logic       s1_fire;

  logic       s2_valid;
  stage_t     s2;
  logic       s2_ready;
  logic       s3_load;

  logic [7:0]        command_state;
  logic [7:0]        command_next;
  logic signed [2:0] zone_x;
  logic signed [2:0] zone_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_offset       <= ADC_OFFSET_RESET;
      inner_zone_limit <= INNER_ZONE_RESET;
      outer_zone_limit <= OUTER_ZONE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ADC_OFFSET: adc_offset       <= cfg_data;
        REG_INNER_ZONE: inner_zone_limit <= cfg_data[6:0];
        REG_OUTER_ZONE: outer_zone_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign s3_load  = s2_valid && (!out_valid || out_ready);
  assign s2_ready = !s2_valid || s3_load;
  assign s1_fire  = s1_valid && (!s1_has_result || s2_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  assign analog_offset = frame_position - POS_ANALOG;
  assign analog_index  = analog_offset[1:0];

  always_comb begin
    frame_position_next = frame_position;
    running_sum_next    = running_sum;
    s1_has_result       = 1'b0;
    s1_result.status    = STATUS_OK;
    s1_result.buttons   = {digital_byte[BTN_FOUR_BIT], digital_byte[BTN_THREE_BIT],
                           digital_byte[BTN_TWO_BIT], digital_byte[BTN_ONE_BIT]};
    s1_result.prod_y    = axis_product(analog_bytes[0], analog_bytes[1], adc_offset);
    s1_result.prod_x    = axis_product(analog_bytes[2], analog_bytes[3], adc_offset);
    if (frame_position == POS_HUNT) begin
      if (s1_byte == START_BYTE) begin
        frame_position_next = frame_position + 5'd1;
        running_sum_next    = TYPE_BYTE;
      end
    end else if (frame_position < POS_TYPE) begin
      frame_position_next = frame_position + 5'd1;
    end else if (frame_position == POS_TYPE) begin
      if (s1_byte != TYPE_BYTE) begin
        frame_position_next = POS_HUNT;
        s1_has_result       = 1'b1;
        s1_result.status    = STATUS_TYPE;
      end else begin
        frame_position_next = frame_position + 5'd1;
      end
    end else if (frame_position < POS_CHECK) begin
      running_sum_next    = running_sum + s1_byte;
      frame_position_next = frame_position + 5'd1;
    end else begin
      frame_position_next = POS_HUNT;
      s1_has_result       = 1'b1;
      s1_result.status    = (s1_byte == ~running_sum) ? STATUS_OK : STATUS_CHECKSUM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= POS_HUNT;
      running_sum    <= TYPE_BYTE;
    end else if (s1_fire) begin
      frame_position <= frame_position_next;
      running_sum    <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && frame_position == POS_DIGITAL) begin
      digital_byte <= s1_byte;
    end
    if (s1_fire && frame_position >= POS_ANALOG && frame_position < POS_CHECK) begin
      analog_bytes[analog_index] <= s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_fire && s1_has_result) begin
      s2_valid <= 1'b1;
    end else if (s3_load) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_has_result) begin
      s2 <= s1_result;
    end
  end

  assign zone_y = axis_zone(s2.prod_y, inner_zone_limit, outer_zone_limit);
  assign zone_x = axis_zone(s2.prod_x, inner_zone_limit, outer_zone_limit);

  always_comb begin
    command_next = command_state;
    if (zone_y == ZONE_MID) begin
      command_next = (command_next | CMD_Y_MID) & ~CMD_Y_NEG;
    end
    if (zone_y == ZONE_NEG_FAR) begin
      command_next = (command_next | CMD_Y_NEG) & ~CMD_Y_MID;
    end
    if (zone_x == ZONE_MID) begin
      command_next = (command_next | CMD_X_MID) & ~CMD_X_NEG;
    end
    if (zone_x == ZONE_NEG_FAR) begin
      command_next = (command_next | CMD_X_NEG) & ~CMD_X_MID;
    end
    if (s2.buttons[0]) begin
      command_next = command_next | CMD_BUTTON;
    end else begin
      command_next = command_next & ~CMD_BUTTON;
    end
    if (zone_x == ZONE_POS_FAR && zone_y == ZONE_POS_FAR) begin
      command_next = command_next & CMD_BUTTON;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_state <= 8'd0;
    end else if (s3_load && s2.status == STATUS_OK) begin
      command_state <= command_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      status <= s2.status;
      if (s2.status == STATUS_OK) begin
        command_bits <= command_next;
        button_one   <= s2.buttons[0];
        button_two   <= s2.buttons[1];
        button_three <= s2.buttons[2];
        button_four  <= s2.buttons[3];
        x_zone       <= zone_x;
        y_zone       <= zone_y;
      end else begin
        command_bits <= command_state;
        button_one   <= 1'b0;
        button_two   <= 1'b0;
        button_three <= 1'b0;
        button_four  <= 1'b0;
        x_zone       <= ZONE_MID;
        y_zone       <= ZONE_MID;
      end
    end
  end

  // The parser position never runs past the checksum byte.
  assert property (@(posedge clk) disable iff (rst) frame_position <= POS_CHECK)
    else $error("frame position out of range");

  // A held result always reports the command byte that is currently in force.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> command_bits == command_state)
    else $error("command output differs from command state");

  // The command byte only moves when an accepted frame leaves the pipeline.
  assert property (@(posedge clk) disable iff (rst)
                   !(s3_load && s2.status == STATUS_OK) |=> $stable(command_state))
    else $error("command state changed without an accepted frame");

  // Rejected frames carry no button or zone information.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && status != STATUS_OK) |->
                   (!button_one && !button_two && !button_three && !button_four &&
                    x_zone == ZONE_MID && y_zone == ZONE_MID))
    else $error("rejected frame carries decoded fields");

endmodule

[verif/joystick_frame_decoder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the joystick frame decoder: scoreboard class, frame stimulus and checks.
module joystick_frame_decoder_tb;
  import jfd_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 180;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_BAD_TYPE
  } frame_kind_t;

  typedef struct {
    status_t           status;
    logic [7:0]        cmd;
    logic              btn_one;
    logic              btn_two;
    logic              btn_three;
    logic              btn_four;
    logic signed [2:0] x_zone;
    logic signed [2:0] y_zone;
  } joy_result_t;

  class frame_scoreboard;
    logic [9:0]  adc_offset;
    logic [6:0]  inner_lim;
    logic [6:0]  outer_lim;
    int          parse_pos;
    logic [7:0]  csum;
    logic [7:0]  dig_latch;
    logic [7:0]  axis_bytes[4];
    logic [7:0]  cmd_byte;
    joy_result_t expected_frames[$];
    int          errors;

    function new();
      adc_offset = ADC_OFFSET_RESET;
      inner_lim = INNER_ZONE_RESET;
      outer_lim = OUTER_ZONE_RESET;
      parse_pos = POS_HUNT;
      csum = TYPE_BYTE;
      cmd_byte = 8'h00;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [9:0] data);
      case (idx)
        REG_ADC_OFFSET: adc_offset = data;
        REG_INNER_ZONE: inner_lim = data[6:0];
        REG_OUTER_ZONE: outer_lim = data[6:0];
        default: ;
      endcase
    endfunction

    function int zone_of(logic [7:0] hi, logic [7:0] lo);
      int raw;
      int mapped;
      int mag;
      int z;
      raw = int'({hi, lo}) - int'(adc_offset);
      if (raw < 0) raw = 0;
      if (raw > 1023) raw = 1023;
      mapped = raw * 200 / 1023 - 100;
      mag = (mapped < 0) ? -mapped : mapped;
      if (mag <= int'(inner_lim)) z = 0;
      else if (mag <= int'(outer_lim)) z = 1;
      else z = 2;
      return (mapped < 0) ? -z : z;
    endfunction

    function void note_byte(logic [7:0] b);
      joy_result_t r;
      int          yz;
      int          xz;
      logic [7:0]  c;
      r.status = STATUS_OK;
      r.cmd = cmd_byte;
      r.btn_one = 1'b0;
      r.btn_two = 1'b0;
      r.btn_three = 1'b0;
      r.btn_four = 1'b0;
      r.x_zone = 3'sd0;
      r.y_zone = 3'sd0;
      if (parse_pos == POS_HUNT) begin
        if (b == START_BYTE) begin
          parse_pos = 1;
          csum = TYPE_BYTE;
        end
        return;
      end
      if (parse_pos < POS_TYPE) begin
        parse_pos++;
        return;
      end
      if (parse_pos == POS_TYPE) begin
        if (b != TYPE_BYTE) begin
          parse_pos = POS_HUNT;
          r.status = STATUS_TYPE;
          expected_frames.push_back(r);
        end else begin
          parse_pos++;
        end
        return;
      end
      if (parse_pos < POS_CHECK) begin
        if (parse_pos == POS_DIGITAL) dig_latch = b;
        else if (parse_pos >= POS_ANALOG) axis_bytes[parse_pos - POS_ANALOG] = b;
        csum = csum + b;
        parse_pos++;
        return;
      end
      parse_pos = POS_HUNT;
      if (b != 8'(8'hFF - csum)) begin
        r.status = STATUS_CHECKSUM;
        expected_frames.push_back(r);
        return;
      end
      yz = zone_of(axis_bytes[0], axis_bytes[1]);
      xz = zone_of(axis_bytes[2], axis_bytes[3]);
      c = cmd_byte;
      if (yz == 0) c = (c | CMD_Y_MID) & ~CMD_Y_NEG;
      if (yz == -2) c = (c | CMD_Y_NEG) & ~CMD_Y_MID;
      if (xz == 0) c = (c | CMD_X_MID) & ~CMD_X_NEG;
      if (xz == -2) c = (c | CMD_X_NEG) & ~CMD_X_MID;
      c[7] = dig_latch[BTN_ONE_BIT];
      if (xz == 2 && yz == 2) c = c & CMD_BUTTON;
      cmd_byte = c;
      r.cmd = c;
      r.btn_one = dig_latch[BTN_ONE_BIT];
      r.btn_two = dig_latch[BTN_TWO_BIT];
      r.btn_three = dig_latch[BTN_THREE_BIT];
      r.btn_four = dig_latch[BTN_FOUR_BIT];
      r.x_zone = 3'(xz);
      r.y_zone = 3'(yz);
      expected_frames.push_back(r);
    endfunction

    function void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(joy_result_t got);
      joy_result_t want;
      if (expected_frames.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none, actual status %0d",
                 $time, got.status);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      check_field("status", want.status, got.status);
      check_field("command_bits", want.cmd, got.cmd);
      check_field("button_one", want.btn_one, got.btn_one);
      check_field("button_two", want.btn_two, got.btn_two);
      check_field("button_three", want.btn_three, got.btn_three);
      check_field("button_four", want.btn_four, got.btn_four);
      check_field("x_zone", want.x_zone, got.x_zone);
      check_field("y_zone", want.y_zone, got.y_zone);
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic [9:0]        cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        status;
  logic [7:0]        command_bits;
  logic              button_one;
  logic              button_two;
  logic              button_three;
  logic              button_four;
  logic signed [2:0] x_zone;
  logic signed [2:0] y_zone;

  frame_scoreboard sb;
  logic [7:0]      byte_queue[$];
  logic [9:0]      cur_offset = ADC_OFFSET_RESET;
  int              send_pct = 0;
  int              recv_pct = 0;
  int              stall_cycles = 0;

  joystick_frame_decoder uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .command_bits(command_bits),
    .button_one(button_one),
    .button_two(button_two),
    .button_three(button_three),
    .button_four(button_four),
    .x_zone(x_zone),
    .y_zone(y_zone)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function logic [15:0] pick_axis();
    int v;
    case ($urandom_range(4))
      0: v = int'($urandom_range(65535));
      1, 2: v = int'(cur_offset) + int'($urandom_range(1023));
      3: v = int'(cur_offset) - int'($urandom_range(40));
      default: v = int'(cur_offset) + 1023 + int'($urandom_range(40));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function void add_frame(frame_kind_t kind, logic [7:0] dig, logic [15:0] y_raw,
                          logic [15:0] x_raw);
    logic [7:0] sum;
    logic [7:0] frame_id;
    logic [7:0] hdr;
    logic [7:0] chk;
    byte_queue.push_back(START_BYTE);
    byte_queue.push_back(8'($urandom));
    byte_queue.push_back(8'($urandom));
    if (kind == FRAME_BAD_TYPE) begin
      frame_id = 8'($urandom);
      if (frame_id == TYPE_BYTE) frame_id = frame_id ^ 8'h01;
      byte_queue.push_back(frame_id);
      return;
    end
    byte_queue.push_back(TYPE_BYTE);
    sum = TYPE_BYTE;
    for (int i = 0; i < 8; i++) begin
      hdr = ($urandom_range(7) == 0) ? START_BYTE : 8'($urandom);
      byte_queue.push_back(hdr);
      sum = sum + hdr;
    end
    byte_queue.push_back(dig);
    byte_queue.push_back(y_raw[15:8]);
    byte_queue.push_back(y_raw[7:0]);
    byte_queue.push_back(x_raw[15:8]);
    byte_queue.push_back(x_raw[7:0]);
    sum = sum + dig + y_raw[15:8] + y_raw[7:0] + x_raw[15:8] + x_raw[7:0];
    chk = 8'hFF - sum;
    if (kind == FRAME_BAD_SUM) chk = chk ^ 8'($urandom_range(255, 1));
    byte_queue.push_back(chk);
  endfunction

  task automatic send_byte(logic [7:0] b);
    if (send_pct > 0) begin
      while ($urandom_range(99) < send_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
  endtask

  task automatic send_stream();
    while (byte_queue.size() != 0) send_byte(byte_queue.pop_front());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic drive_cfg(logic [1:0] idx, logic [9:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic program_limits(logic [9:0] off, logic [6:0] inner, logic [6:0] outer);
    drive_cfg(REG_ADC_OFFSET, off);
    drive_cfg(REG_INNER_ZONE, {3'b000, inner});
    drive_cfg(REG_OUTER_ZONE, {3'b000, outer});
    cfg_write <= 1'b0;
    cur_offset = off;
  endtask

  initial begin
    forever begin
      out_ready <= ($urandom_range(99) >= recv_pct);
      @(posedge clk);
      if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
        sb.check_result('{status_t'(status), command_bits, button_one, button_two,
                          button_three, button_four, x_zone, y_zone});
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b1 || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int          items;
    frame_kind_t kind;
    int          pick;
    sb = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    rx_byte <= 8'h00;
    cfg_write <= 1'b0;
    cfg_index <= REG_ADC_OFFSET;
    cfg_data <= 10'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Noise while hunting, a wrong frame type, then a good frame with both axes clamped.
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'hFF);
    byte_queue.push_back(START_BYTE);
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'h12);
    byte_queue.push_back(8'h00);
    add_frame(FRAME_GOOD, 8'hFF, 16'h0000, 16'hFFFF);
    send_stream();
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_pct = 0; recv_pct = 0; end
        1: begin send_pct = 57; recv_pct = 0; end
        2: begin send_pct = 0; recv_pct = 57; end
        default: begin send_pct = 17; recv_pct = 17; end
      endcase
      case (phase)
        0: program_limits(ADC_OFFSET_RESET, INNER_ZONE_RESET, OUTER_ZONE_RESET);
        1: program_limits(10'd0, 7'd0, 7'd0);
        2: program_limits(10'd1023, 7'd100, 7'd100);
        3: program_limits(10'd300, 7'd100, 7'd0);
        default: program_limits(10'($urandom_range(1023)), 7'($urandom_range(100)),
                                7'($urandom_range(100)));
      endcase
      items = 0;
      while (items < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 94) begin
          kind = (pick < 80) ? FRAME_GOOD : (pick < 88) ? FRAME_BAD_SUM : FRAME_BAD_TYPE;
          add_frame(kind, 8'($urandom), pick_axis(), pick_axis());
          items += byte_queue.size();
        end else begin
          repeat ($urandom_range(3, 1)) byte_queue.push_back(8'($urandom));
        end
        send_stream();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
